/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Property templates for the checker module of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/pbrr_pkg.sv */
// ---------------------------------------------------------------------------
// pbrr_pkg
// Constants, types and register codes of the page bitmap region release block.
// ---------------------------------------------------------------------------
`default_nettype none

package pbrr_pkg;

  // Page geometry and bitmap capacity.
  localparam int PAGE_SHIFT = 12;
  localparam int MAX_PAGES  = 65536;
  localparam int BMP_WORDS  = (MAX_PAGES + 63) / 64;
  localparam int BMP_AW     = (BMP_WORDS > 1) ? $clog2(BMP_WORDS) : 1;

  // Field widths of the ports.
  localparam int ADDR_W  = 64;
  localparam int TYPE_W  = 32;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 32;
  localparam int CNT_W   = 32;
  localparam int END_W   = 53;
  localparam int REL_W   = 17;
  localparam int WORD_W  = 64;

  // Internal widths that follow from the geometry.
  localparam int PGW    = $clog2(MAX_PAGES) + 1;          // page number up to MAX_PAGES
  localparam int WPW    = PGW - 6;                         // bitmap word number
  localparam int EDW    = ADDR_W + 1 - PAGE_SHIFT;         // page number of a 65-bit end
  localparam int XW     = (EDW + 1 > END_W) ? EDW + 1 : END_W;
  localparam int SATW   = (PGW > REL_W) ? PGW : REL_W;
  localparam int IDXXW  = (BMP_AW > IDX_W) ? BMP_AW : IDX_W;

  localparam logic [ADDR_W-1:0] PG_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
  localparam logic [END_W-1:0]  END_MAX = {END_W{1'b1}};
  localparam logic [SATW-1:0]   REL_MAX = SATW'((64'd1 << REL_W) - 64'd1);

  // Configuration register indexes.
  localparam logic [1:0] REG_KERNEL_END = 2'd0;
  localparam logic [1:0] REG_MIN_BASE   = 2'd1;
  localparam logic [1:0] REG_FREE_TYPE  = 2'd2;

  // Item kinds.
  localparam logic KIND_REGION = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SUM,
    ST_BOUND,
    ST_PAGE,
    ST_CLIP,
    ST_CLEAR,
    ST_FLUSH,
    ST_READ,
    ST_REPORT
  } pbrr_state_t;

endpackage

`default_nettype wire

/* src/page_bitmap_region_release.sv */
// ---------------------------------------------------------------------------
// page_bitmap_region_release
// Page-frame bitmap built from memory-map region entries, one bit per page.
// ---------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to all ones, one word per
// cycle, over all 1024 words (BMP_WORDS); busy stays high during the sweep and
// configuration writes are still taken. An item is taken when start is high
// and busy is low, and its single result appears on the result ports for one
// cycle with done high; the receiver cannot stall, so it must take the word
// in that cycle. A bitmap read passes through READ and REPORT before done.
// A region entry passes through SUM, BOUND, PAGE and CLIP, then REPORT if it
// clears nothing; if it clears pages, CLEAR first walks each 64-page bitmap
// word that its free pages touch and FLUSH writes back the last word: the
// clear loop does one read-modify-write of the single-port-read bitmap memory
// per cycle. A new item can be accepted in the same cycle that done is shown.
`default_nettype none

module page_bitmap_region_release
  import pbrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Command channel.
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              kind,
  input  wire logic [ADDR_W-1:0] region_base,
  input  wire logic [ADDR_W-1:0] region_length,
  input  wire logic [TYPE_W-1:0] region_type,
  input  wire logic [IDX_W-1:0]  word_index,
  // Result channel.
  output logic                   done,
  output logic [CNT_W-1:0]       free_pages,
  output logic [END_W-1:0]       total_pages,
  output logic [REL_W-1:0]       pages_released,
  output logic                   capacity_exceeded,
  output logic [WORD_W-1:0]      bitmap_word,
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // Bitmap memory and its ports.
  logic [WORD_W-1:0] bitmap_mem [BMP_WORDS];
  logic              mem_we;
  logic [BMP_AW-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BMP_AW-1:0] mem_raddr;
  logic [WORD_W-1:0] rd_data;

  // Control state.
  pbrr_state_t state, state_next;
  logic [BMP_AW-1:0] init_addr;

  // Configuration registers.
  logic [CFG_W-1:0] kernel_end;
  logic [CFG_W-1:0] min_base;
  logic [CFG_W-1:0] free_type;

  // Running state.
  logic [CNT_W-1:0] free_count;
  logic [END_W-1:0] highest;

  // Latched item.
  logic              kind_q;
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] length_q;
  logic [TYPE_W-1:0] type_q;
  logic [IDXXW-1:0]  idx_q;

  // Datapath stages.
  logic [ADDR_W:0]   sum_q;
  logic [EDW-1:0]    end_down;
  logic [END_W-1:0]  end_up;
  logic              eligible;
  logic [ADDR_W-1:0] start_addr;
  logic [EDW-1:0]    first_page;
  logic [REL_W-1:0]  released;
  logic              flag;

  // Clear loop.
  logic [WPW-1:0]    wp;
  logic [WPW-1:0]    first_w;
  logic [WPW-1:0]    last_w;
  logic [5:0]        lo_bit;
  logic [5:0]        hi_bit;
  logic              wr_pend;
  logic [BMP_AW-1:0] wr_addr;
  logic [WORD_W-1:0] wr_mask;

  // Combinational helpers.
  logic [CFG_W:0]    kend_round;
  logic [CFG_W:0]    floor_c;
  logic [XW-1:0]     end_up_x;
  logic              clip_cond;
  logic              clip_over;
  logic [PGW-1:0]    hi_c;
  logic              clip_act;
  logic [PGW-1:0]    cnt_c;
  logic [PGW-1:0]    hi_m1;
  logic [CNT_W:0]    free_sum;
  logic [5:0]        mask_lo;
  logic [5:0]        mask_hi;
  logic [WORD_W-1:0] mask_c;
  logic              idx_ok;

  assign cfg_ready = 1'b1;

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= bitmap_mem[mem_raddr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (init_addr == BMP_AW'(BMP_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = (kind == KIND_READ) ? ST_READ : ST_SUM;
      end
      ST_SUM:    state_next = ST_BOUND;
      ST_BOUND:  state_next = ST_PAGE;
      ST_PAGE:   state_next = ST_CLIP;
      ST_CLIP:   state_next = clip_act ? ST_CLEAR : ST_REPORT;
      ST_CLEAR: begin
        if (wp == last_w) state_next = ST_FLUSH;
      end
      ST_FLUSH:  state_next = ST_REPORT;
      ST_READ:   state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State-driven controls and memory port selection.
  always_comb begin
    busy      = (state != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = rd_data & ~wr_mask;
    mem_re    = 1'b0;
    mem_raddr = wp[BMP_AW-1:0];
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
        mem_wdata = {WORD_W{1'b1}};
      end
      ST_CLEAR: begin
        mem_re = 1'b1;
        mem_we = wr_pend;
      end
      ST_FLUSH: begin
        mem_we = wr_pend;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = BMP_AW'(idx_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Floor of releasable addresses: kernel end rounded up, or the minimum base if higher; also the rounded-up end page.
  always_comb begin
    kend_round = ({1'b0, kernel_end} + (CFG_W + 1)'(PG_MASK)) & ~((CFG_W + 1)'(PG_MASK));
    floor_c    = (kend_round < {1'b0, min_base}) ? {1'b0, min_base} : kend_round;
    end_up_x   = XW'(sum_q[ADDR_W:PAGE_SHIFT]) +
                 XW'(sum_q[PAGE_SHIFT-1:0] != '0);
  end

  // Clip against capacity and count the pages.
  always_comb begin
    clip_cond = eligible && (end_down > first_page);
    clip_over = end_down > EDW'(MAX_PAGES);
    hi_c      = clip_over ? PGW'(MAX_PAGES) : PGW'(end_down);
    clip_act  = clip_cond && (first_page < EDW'(hi_c));
    cnt_c     = hi_c - PGW'(first_page);
    hi_m1     = hi_c - PGW'(1);
    free_sum  = {1'b0, free_count} + (CNT_W + 1)'(cnt_c);
  end

  // Mask of the pages to clear in the current word.
  always_comb begin
    mask_lo = (wp == first_w) ? lo_bit : 6'd0;
    mask_hi = (wp == last_w) ? hi_bit : 6'd63;
    mask_c  = ({WORD_W{1'b1}} << mask_lo) & ({WORD_W{1'b1}} >> (6'd63 - mask_hi));
  end

  assign idx_ok = {1'b0, idx_q} < (IDXXW + 1)'(BMP_WORDS);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_addr  <= '0;
      done       <= 1'b0;
      wr_pend    <= 1'b0;
      kernel_end <= '0;
      min_base   <= 32'h0010_0000;
      free_type  <= 32'd1;
      free_count <= '0;
      highest    <= '0;
    end else begin
      state   <= state_next;
      done    <= (state == ST_REPORT);
      wr_pend <= (state == ST_CLEAR);
      if (state == ST_INIT) begin
        init_addr <= init_addr + BMP_AW'(1);
      end
      // Configuration writes; indexes past the list are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_END: kernel_end <= cfg_data;
          REG_MIN_BASE:   min_base   <= cfg_data;
          REG_FREE_TYPE:  free_type  <= cfg_data;
          default:        ;
        endcase
      end
      // Running totals are updated once the clipped range is known.
      if (state == ST_CLIP) begin
        if (end_up > highest) highest <= end_up;
        if (clip_act) begin
          free_count <= free_sum[CNT_W] ? {CNT_W{1'b1}} : free_sum[CNT_W-1:0];
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Latch the item at accept.
    if (state == ST_IDLE && start) begin
      kind_q   <= kind;
      base_q   <= region_base;
      length_q <= region_length;
      type_q   <= region_type;
      idx_q    <= IDXXW'(word_index);
    end
    // Exact 65-bit region end.
    if (state == ST_SUM) begin
      sum_q <= {1'b0, base_q} + {1'b0, length_q};
    end
    // Page ends, eligibility and clipped start address.
    if (state == ST_BOUND) begin
      end_down   <= sum_q[ADDR_W:PAGE_SHIFT];
      end_up     <= (end_up_x > XW'(END_MAX)) ? END_MAX : END_W'(end_up_x);
      eligible   <= (type_q == free_type) && (sum_q > (ADDR_W + 1)'(floor_c));
      start_addr <= (base_q < ADDR_W'(floor_c)) ? ADDR_W'(floor_c) : base_q;
    end
    // First whole page of the region.
    if (state == ST_PAGE) begin
      first_page <= EDW'(start_addr >> PAGE_SHIFT) +
                    EDW'((start_addr & PG_MASK) != '0);
    end
    // Clear-loop bounds and reported figures.
    if (state == ST_CLIP) begin
      flag     <= clip_cond && clip_over;
      released <= !clip_act ? '0 :
                  (SATW'(cnt_c) > REL_MAX) ? REL_W'(REL_MAX) : REL_W'(cnt_c);
      wp       <= first_page[PGW-1:6];
      first_w  <= first_page[PGW-1:6];
      last_w   <= hi_m1[PGW-1:6];
      lo_bit   <= first_page[5:0];
      hi_bit   <= hi_m1[5:0];
    end
    // One word a cycle: read now, write the cleared word next cycle.
    if (state == ST_CLEAR) begin
      wp      <= wp + WPW'(1);
      wr_addr <= wp[BMP_AW-1:0];
      wr_mask <= mask_c;
    end
    // Result word.
    if (state == ST_REPORT) begin
      free_pages  <= free_count;
      total_pages <= highest;
      if (kind_q == KIND_READ) begin
        pages_released    <= '0;
        capacity_exceeded <= 1'b0;
        bitmap_word       <= idx_ok ? rd_data : {WORD_W{1'b1}};
      end else begin
        pages_released    <= released;
        capacity_exceeded <= flag;
        bitmap_word       <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/pbrr_checker.sv */
// ---------------------------------------------------------------------------
// pbrr_checker
// Port-level checks on the command and result timing and the result fields of the bitmap block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pbrr_checker
  import pbrr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [REL_W-1:0]  pages_released,
  input wire logic              capacity_exceeded,
  input wire logic [WORD_W-1:0] bitmap_word
);

  // An accepted word keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // No result can come out the cycle right after an accept.
  `ASSERT_NEXT(a_accept_no_done, clk, rst, start && !busy, !done)

  // A region entry that released pages reports an empty bitmap word.
  `ASSERT_SAME(a_release_word, clk, rst, done && (pages_released != '0),
               bitmap_word == '0)

  // A capacity overrun can only come from a region entry.
  `ASSERT_SAME(a_capacity_word, clk, rst, done && capacity_exceeded,
               bitmap_word == '0)

endmodule

bind page_bitmap_region_release pbrr_checker u_pbrr_checker (.*);

`default_nettype wire

/* dv/tb_page_bitmap_region_release.sv */
// ---------------------------------------------------------------------------
// tb_page_bitmap_region_release
// Drives memory-map region entries and bitmap reads into the page bitmap
// block, predicts each result word from a local copy of the bitmap, the free
// count and the highest end page, and compares every field of every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_page_bitmap_region_release;
  import pbrr_pkg::*;

  // Cycles with no handshake at all before the run is declared hung. The
  // slowest legal stretch is the post-reset sweep or a region that clears
  // the whole bitmap.
  localparam int QUIET_LIMIT = 20000;
  // Cycles to watch for stray results once everything has been checked.
  localparam int TAIL_CYCLES = 40;
  // Type codes used by the directed part, which runs on the reset settings.
  localparam logic [TYPE_W-1:0] RESET_FREE_CODE = 32'd1;
  localparam logic [TYPE_W-1:0] RESERVED_CODE   = 32'd2;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic [TYPE_W-1:0] rtype;
    logic [IDX_W-1:0]  widx;
  } pbrr_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  free_pages;
    logic [END_W-1:0]  total_pages;
    logic [REL_W-1:0]  released;
    logic              over_cap;
    logic [WORD_W-1:0] word;
  } pbrr_result_t;

  // Clock, reset and block ports.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = KIND_REGION;
  logic [ADDR_W-1:0] region_base = '0;
  logic [ADDR_W-1:0] region_length = '0;
  logic [TYPE_W-1:0] region_type = '0;
  logic [IDX_W-1:0]  word_index = '0;
  logic              done;
  logic [CNT_W-1:0]  free_pages;
  logic [END_W-1:0]  total_pages;
  logic [REL_W-1:0]  pages_released;
  logic              capacity_exceeded;
  logic [WORD_W-1:0] bitmap_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_KERNEL_END;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Local copy of the block state and its settings.
  logic [WORD_W-1:0] page_map [0:BMP_WORDS-1];
  logic [CNT_W-1:0]  free_tally;
  logic [END_W-1:0]  top_end_page;
  logic [CFG_W-1:0]  kernel_end_r;
  logic [CFG_W-1:0]  min_base_r;
  logic [CFG_W-1:0]  free_code_r;

  // Command words waiting to be sent and result words waiting to arrive.
  pbrr_item_t   pending_items [$];
  pbrr_result_t results_due [$];

  int          n_queued = 0;
  int          n_checked = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  logic        cmd_fire_q = 1'b0;

  page_bitmap_region_release uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // One line per mismatch, for the first 200, and a running count.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 200)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Lowest address that may be released under the current settings.
  function automatic logic [63:0] release_floor();
    logic [63:0] kend;
    kend = ((64'(kernel_end_r) + PG_MASK) >> PAGE_SHIFT) << PAGE_SHIFT;
    return (kend < 64'(min_base_r)) ? 64'(min_base_r) : kend;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < BMP_WORDS; i++) page_map[i] = '1;
    free_tally   = '0;
    top_end_page = '0;
    kernel_end_r = '0;
    min_base_r   = 32'h0010_0000;
    free_code_r  = 32'd1;
  endtask

  // Applies one command word to the local state and forms its result word.
  task automatic predict_release(input pbrr_item_t it, output pbrr_result_t r);
    logic [64:0] end_sum;
    logic [63:0] end_down;
    logic [63:0] end_up;
    logic [63:0] floor_addr;
    logic [63:0] first_addr;
    logic [63:0] first_page;
    logic [63:0] last_page;
    logic [63:0] n_pages;
    logic [63:0] tally;
    int          pg;
    r = '0;
    if (it.kind == KIND_READ) begin
      r.word = (int'(it.widx) < BMP_WORDS) ? page_map[it.widx] : '1;
    end else begin
      // The end is kept with its carry, so a wrapping region still counts.
      end_sum  = {1'b0, it.base} + {1'b0, it.length};
      end_down = 64'(end_sum >> PAGE_SHIFT);
      end_up   = end_down + 64'((end_sum & 65'(PG_MASK)) != 0);
      if (end_up > 64'(END_MAX)) end_up = 64'(END_MAX);
      if (end_up > 64'(top_end_page)) top_end_page = END_W'(end_up);
      if (it.rtype == free_code_r) begin
        floor_addr = release_floor();
        if (end_sum > {1'b0, floor_addr}) begin
          first_addr = (it.base < floor_addr) ? floor_addr : it.base;
          first_page = (first_addr >> PAGE_SHIFT) + 64'((first_addr & PG_MASK) != 0);
          if (end_down > first_page) begin
            last_page = end_down;
            // Pages past the bitmap are dropped and flagged.
            if (last_page > 64'(MAX_PAGES)) begin
              r.over_cap = 1'b1;
              last_page  = 64'(MAX_PAGES);
            end
            if (first_page < last_page) begin
              n_pages = last_page - first_page;
              for (pg = int'(first_page); pg < int'(last_page); pg++)
                page_map[pg >> 6][pg & 63] = 1'b0;
              // Pages that were already free count again.
              tally = 64'(free_tally) + n_pages;
              free_tally = (tally > 64'hFFFF_FFFF) ? '1 : tally[CNT_W-1:0];
              r.released = (n_pages > 64'({REL_W{1'b1}})) ? '1 : n_pages[REL_W-1:0];
            end
          end
        end
      end
    end
    r.free_pages  = free_tally;
    r.total_pages = top_end_page;
  endtask

  // Sends the next queued command word, with random gaps between words.
  always @(negedge clk) begin : drive_cmd
    pbrr_item_t nxt;
    logic       go;
    go = start;
    if (rst) begin
      go = 1'b0;
    end else if (!start || cmd_fire_q) begin
      go = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_items.pop_front();
        kind          <= nxt.kind;
        region_base   <= nxt.base;
        region_length <= nxt.length;
        region_type   <= nxt.rtype;
        word_index    <= nxt.widx;
        go = 1'b1;
      end
    end
    start <= go;
  end

  // Watches all three channels: checks results, tracks settings, predicts.
  always @(posedge clk) begin : watch_ports
    pbrr_item_t   seen;
    pbrr_result_t want;
    if (rst) begin
      reset_predictor();
      cmd_fire_q   = 1'b0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      // Results are checked before this edge's command is predicted, since
      // the result of the previous command may leave as the next one enters.
      if (done) begin
        quiet_cycles = 0;
        if (results_due.size() == 0) begin
          report_mismatch("unrequested result", 64'(free_pages), 64'd0);
        end else begin
          want = results_due.pop_front();
          if (free_pages !== want.free_pages)
            report_mismatch("free_pages", 64'(free_pages), 64'(want.free_pages));
          if (total_pages !== want.total_pages)
            report_mismatch("total_pages", 64'(total_pages), 64'(want.total_pages));
          if (pages_released !== want.released)
            report_mismatch("pages_released", 64'(pages_released), 64'(want.released));
          if (capacity_exceeded !== want.over_cap)
            report_mismatch("capacity_exceeded", 64'(capacity_exceeded),
                            64'(want.over_cap));
          if (bitmap_word !== want.word)
            report_mismatch("bitmap_word", bitmap_word, want.word);
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          REG_KERNEL_END: kernel_end_r = cfg_data;
          REG_MIN_BASE:   min_base_r   = cfg_data;
          REG_FREE_TYPE:  free_code_r  = cfg_data;
          default: ;
        endcase
      end
      cmd_fire_q = start && !busy;
      if (cmd_fire_q) begin
        quiet_cycles = 0;
        seen.kind   = kind;
        seen.base   = region_base;
        seen.length = region_length;
        seen.rtype  = region_type;
        seen.widx   = word_index;
        predict_release(seen, want);
        results_due.push_back(want);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_page_bitmap_region_release: errors");
        $finish;
      end
    end
  end

  task automatic queue_item(input pbrr_item_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  function automatic pbrr_item_t region(input logic [63:0] base, input logic [63:0] len,
                                        input logic [31:0] rtype);
    pbrr_item_t it;
    it.kind   = KIND_REGION;
    it.base   = base;
    it.length = len;
    it.rtype  = rtype;
    it.widx   = '0;
    return it;
  endfunction

  function automatic pbrr_item_t read_word(input logic [IDX_W-1:0] idx);
    pbrr_item_t it;
    it        = region('0, '0, '0);
    it.kind   = KIND_READ;
    it.widx   = idx;
    return it;
  endfunction

  // Bitmap reads a quarter of the time, else mostly well-formed entries near
  // where behavior turns: the release floor, the bitmap capacity, low memory.
  function automatic pbrr_item_t random_entry();
    pbrr_item_t  it;
    int unsigned pick;
    int unsigned span;
    logic [63:0] anchor;
    logic [63:0] floor_addr;
    it.kind   = KIND_REGION;
    it.base   = {$urandom, $urandom};
    it.length = {$urandom, $urandom};
    it.rtype  = $urandom;
    it.widx   = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.kind = KIND_READ;
    end else if (pick < 90) begin
      floor_addr = release_floor();
      case ($urandom_range(5))
        4: anchor = ((floor_addr >= 64'h1_0000) ? floor_addr - 64'h1_0000 : 64'd0) +
                    64'($urandom_range(32'h2_0000));
        5: anchor = 64'h0FF0_0000 + 64'($urandom_range(32'h20_0000));
        default: anchor = 64'($urandom_range(32'h0FFF_FFFF)) & ~PG_MASK;
      endcase
      if ($urandom_range(2) == 0) anchor = anchor + 64'($urandom_range(4095));
      span = ($urandom_range(19) == 0) ? $urandom_range(4096) : $urandom_range(200);
      it.base   = anchor;
      it.length = (64'(span) << PAGE_SHIFT) +
                  (($urandom_range(3) == 0) ? 64'($urandom_range(4095)) : 64'd0);
      it.rtype  = (pick < 80) ? free_code_r : free_code_r + 32'($urandom_range(1, 4));
    end else begin
      // Noise: any address and length, free type half of the time.
      if ($urandom_range(1) == 0) it.rtype = free_code_r;
    end
    return it;
  endfunction

  // Holds the sender until every result word owed so far has been checked.
  task automatic settle_results();
    wait (n_checked == n_queued);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One phase: new settings on an idle block, then random command words.
  task automatic run_phase(input logic [CFG_W-1:0] kend, input logic [CFG_W-1:0] minb,
                           input logic [CFG_W-1:0] fcode, input int unsigned idle_pct,
                           input int count);
    settle_results();
    write_reg(REG_KERNEL_END, kend);
    write_reg(REG_MIN_BASE, minb);
    write_reg(REG_FREE_TYPE, fcode);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      while (pending_items.size() >= 8) @(posedge clk);
      queue_item(random_entry());
      if (n % 97 == 96) settle_results();
    end
    settle_results();
  endtask

  initial begin : run_test
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 22;

    // Directed words on the reset settings: floor at 1 MiB, free type 1.
    queue_item(read_word(10'd0));
    queue_item(read_word(10'd1023));
    queue_item(region(64'h0, 64'h20_0000, RESET_FREE_CODE));          // clipped at floor
    queue_item(read_word(10'd4));
    queue_item(region(64'h0, 64'h8_0000, RESET_FREE_CODE));           // ends below floor
    queue_item(region(64'h20_0100, 64'h800, RESET_FREE_CODE));        // no whole page
    queue_item(region(64'h30_0800, 64'h5000, RESET_FREE_CODE));       // unaligned ends
    queue_item(region(64'h30_0800, 64'h5000, RESET_FREE_CODE));       // released again
    queue_item(region(64'h40_0000, 64'h10_0000, RESERVED_CODE));
    queue_item(region(64'h0FFF_0000, 64'h4_0000, RESET_FREE_CODE));   // crosses capacity
    queue_item(region(64'h2000_0000, 64'h1000, RESET_FREE_CODE));     // past capacity
    queue_item(region(64'hFFFF_FFFF_FFFF_F000, 64'h2000, RESET_FREE_CODE));  // end carries
    queue_item(region('1, '1, RESERVED_CODE));                         // end saturates
    queue_item(region(64'h50_0000, 64'h0, RESET_FREE_CODE));          // empty
    queue_item(region(64'h0, 64'h0, 32'hFFFF_FFFF));
    queue_item(region(64'h60_0000, 64'h1000, 32'h0));
    queue_item(read_word(10'd1023));
    queue_item(read_word(10'h00C));
    queue_item(read_word(10'h2AA));
    queue_item(read_word(10'h155));
    queue_item(region(64'h100_0000, 64'h4_0000, RESET_FREE_CODE));    // one whole word
    queue_item(read_word(10'd64));
    queue_item(region('1, 64'h0, RESET_FREE_CODE));

    // Random phases: sender gaps 22%, then 76%, then none.
    run_phase(32'h0, 32'h0, 32'h0, 22, 400);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 76, 100);
    run_phase(32'h00A0_1234, 32'h0080_0000, 32'h5A5A_0003, 76, 250);
    run_phase(32'($urandom_range(32'h0400_0000)), 32'($urandom_range(32'h0400_0000)),
              32'd1, 0, 380);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("missing results", 64'(results_due.size()), 64'd0);
    if (error_count == 0) begin
      $display("tb_page_bitmap_region_release: clean");
    end else begin
      $display("tb_page_bitmap_region_release: errors");
    end
    $finish;
  end

endmodule
